// ===== hw/rtl/pbch_pkg.sv =====
// Shared constants, tables and elaboration-time functions of the PBCH polar encoder.
package pbch_pkg;

   localparam int PayBits   = 32;
   localparam int CrcBits   = 24;
   localparam int InfoBits  = 56;
   localparam int MotherN   = 512;
   localparam int IlMax     = 164;
   localparam int GoldNc    = 1600;
   localparam int ScrSpan   = 29;
   localparam int CodeE     = 864;
   localparam int WordBits  = 32;
   localparam int WordCount = CodeE / WordBits;
   localparam int StoreDepth = MotherN / WordBits;
   localparam int GoldCntBits = 13;
   localparam logic [CrcBits-1:0] CrcPoly = 24'h864CFB;

   typedef logic [InfoBits-1:0][8:0] info_rom_type;
   typedef logic [InfoBits-1:0][5:0] il_src_type;

   localparam logic [4:0] PayMap [PayBits] = '{
      5'd16, 5'd23, 5'd18, 5'd17, 5'd8,  5'd30, 5'd1,  5'd4,
      5'd9,  5'd11, 5'd12, 5'd13, 5'd14, 5'd15, 5'd19, 5'd20,
      5'd21, 5'd22, 5'd25, 5'd26, 5'd27, 5'd28, 5'd29, 5'd31,
      5'd10, 5'd6,  5'd24, 5'd7,  5'd0,  5'd5,  5'd3,  5'd2};

   localparam logic [7:0] IlPattern [IlMax] = '{
      8'd0,   8'd2,   8'd4,   8'd7,   8'd9,   8'd14,  8'd19,  8'd20,  8'd24,  8'd25,
      8'd26,  8'd28,  8'd31,  8'd34,  8'd42,  8'd45,  8'd49,  8'd50,  8'd51,  8'd53,
      8'd54,  8'd56,  8'd58,  8'd59,  8'd61,  8'd62,  8'd65,  8'd66,  8'd67,  8'd69,
      8'd70,  8'd71,  8'd72,  8'd76,  8'd77,  8'd81,  8'd82,  8'd83,  8'd87,  8'd88,
      8'd89,  8'd91,  8'd93,  8'd95,  8'd98,  8'd101, 8'd104, 8'd106, 8'd108, 8'd110,
      8'd111, 8'd113, 8'd115, 8'd118, 8'd119, 8'd120, 8'd122, 8'd123, 8'd126, 8'd127,
      8'd129, 8'd132, 8'd134, 8'd138, 8'd139, 8'd140, 8'd1,   8'd3,   8'd5,   8'd8,
      8'd10,  8'd15,  8'd21,  8'd27,  8'd29,  8'd32,  8'd35,  8'd43,  8'd46,  8'd52,
      8'd55,  8'd57,  8'd60,  8'd63,  8'd68,  8'd73,  8'd78,  8'd84,  8'd90,  8'd92,
      8'd94,  8'd96,  8'd99,  8'd102, 8'd105, 8'd107, 8'd109, 8'd112, 8'd114, 8'd116,
      8'd121, 8'd124, 8'd128, 8'd130, 8'd133, 8'd135, 8'd141, 8'd6,   8'd11,  8'd16,
      8'd22,  8'd30,  8'd33,  8'd36,  8'd44,  8'd47,  8'd64,  8'd74,  8'd79,  8'd85,
      8'd97,  8'd100, 8'd103, 8'd117, 8'd125, 8'd131, 8'd136, 8'd142, 8'd12,  8'd17,
      8'd23,  8'd37,  8'd48,  8'd75,  8'd80,  8'd86,  8'd137, 8'd143, 8'd13,  8'd18,
      8'd38,  8'd144, 8'd39,  8'd145, 8'd40,  8'd146, 8'd41,  8'd147, 8'd148, 8'd149,
      8'd150, 8'd151, 8'd152, 8'd153, 8'd154, 8'd155, 8'd156, 8'd157, 8'd158, 8'd159,
      8'd160, 8'd161, 8'd162, 8'd163};

   localparam logic [4:0] SbPerm [32] = '{
      5'd0,  5'd1,  5'd2,  5'd4,  5'd3,  5'd5,  5'd6,  5'd7,
      5'd8,  5'd16, 5'd9,  5'd17, 5'd10, 5'd18, 5'd11, 5'd19,
      5'd12, 5'd20, 5'd13, 5'd21, 5'd14, 5'd22, 5'd15, 5'd23,
      5'd24, 5'd25, 5'd26, 5'd28, 5'd27, 5'd29, 5'd30, 5'd31};

   function automatic longint unsigned int_sqrt(longint unsigned v);
      longint unsigned rem;
      longint unsigned res;
      longint unsigned bv;
      rem = v;
      res = 0;
      bv = 64'h4000_0000_0000_0000;
      while (bv > rem) bv = bv >> 2;
      while (bv != 0) begin
         if (rem >= res + bv) begin
            rem = rem - (res + bv);
            res = (res >> 1) + bv;
         end else begin
            res = res >> 1;
         end
         bv = bv >> 2;
      end
      return res;
   endfunction

   // Information positions in ascending polarization weight, weights in Q31.
   function automatic info_rom_type info_rom_gen();
      longint unsigned base [4];
      longint unsigned w [MotherN];
      int above;
      info_rom_type r;
      r = '0;
      base[0] = 64'd1 << 31;
      base[2] = int_sqrt(64'd1 << 63);
      base[1] = int_sqrt(base[2] << 31);
      base[3] = (base[1] * base[2]) >> 31;
      for (int i = 0; i < MotherN; i++) begin
         w[i] = 0;
         for (int j = 0; j < 9; j++) begin
            if (((i >> j) & 1) == 1) w[i] = w[i] + (base[j & 3] << (j >> 2));
         end
      end
      for (int i = 0; i < MotherN; i++) begin
         above = 0;
         for (int o = 0; o < MotherN; o++) begin
            if (w[o] > w[i] || (w[o] == w[i] && o > i)) above++;
         end
         if (above < InfoBits) r[InfoBits-1-above] = 9'(i);
      end
      return r;
   endfunction

   // Payload bit feeding each interleaved position.
   function automatic il_src_type il_src_gen();
      int j;
      il_src_type r;
      r = '0;
      j = 0;
      for (int i = 0; i < IlMax; i++) begin
         if (int'(IlPattern[i]) >= IlMax - InfoBits && j < InfoBits) begin
            r[j] = 6'(int'(IlPattern[i]) - (IlMax - InfoBits));
            j++;
         end
      end
      return r;
   endfunction

   localparam info_rom_type InfoRom = info_rom_gen();
   localparam il_src_type IlSrc = il_src_gen();

endpackage

// ===== hw/rtl/pbch_ram.sv =====
// Generic single-port-write, registered-read RAM.
module pbch_ram #(
   parameter int Width = 32,
   parameter int Depth = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);

   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/pbch_gold.sv =====
// Gold sequence generator built from two 31-bit LFSRs.
module pbch_gold (
   input  logic       clock,
   input  logic       reset,
   input  logic       load,
   input  logic [9:0] seed,
   input  logic       step,
   output logic       gold_bit
);

   logic [30:0] x1_ff, x1_in;
   logic [30:0] x2_ff, x2_in;

   always_comb begin
      x1_in = x1_ff;
      x2_in = x2_ff;
      if (load) begin
         x1_in = 31'd1;
         x2_in = {21'd0, seed};
      end else if (step) begin
         x1_in = {x1_ff[0] ^ x1_ff[3], x1_ff[30:1]};
         x2_in = {x2_ff[0] ^ x2_ff[1] ^ x2_ff[2] ^ x2_ff[3], x2_ff[30:1]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         x1_ff <= 31'd1;
         x2_ff <= '0;
      end else begin
         x1_ff <= x1_in;
         x2_ff <= x2_in;
      end
   end

   assign gold_bit = x1_ff[0] ^ x2_ff[0];

endmodule

// ===== hw/rtl/pbch_polar_channel_encoder.sv =====
// Top level of the PBCH polar channel encoder.
//
// One input word on the req_ stream carries a MIB, the frame number, the
// half-frame bit and the SSB index. The block answers with 27 output words
// on the rsp_ stream, each holding 32 coded bits and its word index, with
// tlast on the 27th word. The cell identity must be written over the csr_ port
// only while the block is idle; the block itself does not enforce this.
// An item runs through four phases: the Gold generator is advanced one step
// a cycle to the payload scrambling offset 1600 + 29*((sfn>>1)&3), the payload
// is scrambled and CRC-coded one bit a cycle, the polar code is computed one
// bit a cycle into the codeword RAM, and the Gold generator is advanced to the
// codeword offset 1600 + 864 times the SSB index. Each output word then takes
// a RAM read, a capture of the read data and the generation of its 32-bit Gold
// mask. A new word is accepted once the last output word is taken.
// Reset clears the control state and sets the cell identity to zero. When
// the receiver stalls, the current output word is held and work pauses.
module pbch_polar_channel_encoder (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // mib_bits[23:0], frame_number[33:24], half_frame[34], ssb_index[37:35]
   input  logic [39:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // coded_word[31:0], word_index[36:32]
   output logic [39:0] rsp_tdata,
   output logic        rsp_tlast,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import pbch_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE, S_G1, S_SCR, S_ENC, S_G2, S_RD, S_CAP, S_MASK, S_OUT
   } state_type;

   state_type state_ff, state_in;
   logic [9:0]  cell_id_ff, cell_id_in;
   logic [GoldCntBits-1:0] cnt_ff, cnt_in;
   logic [8:0]  pos_ff, pos_in;
   logic [4:0]  k_ff, k_in;
   logic [31:0] p_ff, p_in;
   logic [31:0] pay_ff, pay_in;
   logic [CrcBits-1:0] crc_ff, crc_in;
   logic [2:0]  ssb_ff, ssb_in;
   logic [31:0] word_ff, word_in;
   logic [31:0] data_ff, data_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [31:0] rsp_word_ff, rsp_word_in;

   logic [31:0] a_vec;
   logic [31:0] p_new;
   logic [InfoBits-1:0] il;
   logic [55:0] pay56;
   logic [8:0]  src;
   logic        enc_bit;
   logic        scr_bit;
   logic        skip;
   logic        fb;
   logic        gold_load, gold_step, gold_bit;
   logic        ram_we, ram_re;
   logic [31:0] ram_rdata;
   logic        accept;

   pbch_gold u_gold (
      .clock    (clock),
      .reset    (reset),
      .load     (gold_load),
      .seed     (cell_id_ff),
      .step     (gold_step),
      .gold_bit (gold_bit)
   );

   pbch_ram #(
      .Width (WordBits),
      .Depth (StoreDepth)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (pos_ff[8:5]),
      .wr_data (word_in),
      .rd_en   (ram_re),
      .rd_addr (k_ff[3:0]),
      .rd_data (ram_rdata)
   );

   assign accept = req_tvalid && req_tready;
   assign req_tready = (state_ff == S_IDLE);

   always_comb begin
      for (int i = 0; i < 24; i++) a_vec[i] = req_tdata[23-i];
      a_vec[24] = req_tdata[27];
      a_vec[25] = req_tdata[26];
      a_vec[26] = req_tdata[25];
      a_vec[27] = req_tdata[24];
      a_vec[28] = req_tdata[34];
      a_vec[31:29] = '0;
      p_new = '0;
      for (int i = 0; i < PayBits; i++) p_new[PayMap[i]] = a_vec[i];
   end

   assign pay56 = {pay_ff, crc_ff};
   assign src = {SbPerm[pos_ff[8:4]], pos_ff[3:0]};

   always_comb begin
      for (int k = 0; k < InfoBits; k++) il[k] = pay56[6'(55) - IlSrc[k]];
      enc_bit = 1'b0;
      for (int k = 0; k < InfoBits; k++) begin
         enc_bit = enc_bit ^ (il[k] & ((InfoRom[k] & src) == src));
      end
   end

   // Payload positions of the half-frame bit and two frame bits stay unscrambled.
   assign skip = (pos_ff[4:0] == 5'd0) || (pos_ff[4:0] == 5'd6) || (pos_ff[4:0] == 5'd24);
   assign scr_bit = p_ff[pos_ff[4:0]] ^ (skip ? 1'b0 : gold_bit);
   assign fb = crc_ff[CrcBits-1] ^ scr_bit;

   always_comb begin
      state_in = state_ff;
      cell_id_in = cell_id_ff;
      cnt_in = cnt_ff;
      pos_in = pos_ff;
      k_in = k_ff;
      p_in = p_ff;
      pay_in = pay_ff;
      crc_in = crc_ff;
      ssb_in = ssb_ff;
      word_in = word_ff;
      data_in = data_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_word_in = rsp_word_ff;
      gold_load = 1'b0;
      gold_step = 1'b0;
      ram_we = 1'b0;
      ram_re = 1'b0;

      if (csr_psel && csr_penable && csr_pwrite && csr_paddr[2] == 1'b0) begin
         cell_id_in = csr_pwdata[9:0];
      end

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               p_in = p_new;
               ssb_in = req_tdata[37:35];
               gold_load = 1'b1;
               cnt_in = GoldCntBits'(GoldNc)
                      + GoldCntBits'(ScrSpan) * GoldCntBits'(req_tdata[26:25]);
               state_in = S_G1;
            end
         end
         S_G1: begin
            if (cnt_ff != '0) begin
               gold_step = 1'b1;
               cnt_in = cnt_ff - 1'b1;
            end else begin
               pos_in = '0;
               crc_in = '0;
               state_in = S_SCR;
            end
         end
         S_SCR: begin
            gold_step = !skip;
            pay_in = {pay_ff[30:0], scr_bit};
            crc_in = {crc_ff[CrcBits-2:0], 1'b0} ^ (fb ? CrcPoly : '0);
            if (pos_ff[4:0] == 5'd31) begin
               pos_in = '0;
               state_in = S_ENC;
            end else begin
               pos_in = pos_ff + 1'b1;
            end
         end
         S_ENC: begin
            word_in = {word_ff[30:0], enc_bit};
            ram_we = (pos_ff[4:0] == 5'd31);
            pos_in = pos_ff + 1'b1;
            if (pos_ff == 9'(MotherN - 1)) begin
               gold_load = 1'b1;
               cnt_in = GoldCntBits'(GoldNc)
                      + GoldCntBits'(CodeE) * GoldCntBits'(ssb_ff);
               state_in = S_G2;
            end
         end
         S_G2: begin
            if (cnt_ff != '0) begin
               gold_step = 1'b1;
               cnt_in = cnt_ff - 1'b1;
            end else begin
               k_in = '0;
               state_in = S_RD;
            end
         end
         S_RD: begin
            ram_re = 1'b1;
            state_in = S_CAP;
         end
         S_CAP: begin
            data_in = ram_rdata;
            pos_in = '0;
            state_in = S_MASK;
         end
         S_MASK: begin
            gold_step = 1'b1;
            word_in = {word_ff[30:0], gold_bit};
            pos_in = pos_ff + 1'b1;
            if (pos_ff[4:0] == 5'd31) begin
               rsp_valid_in = 1'b1;
               rsp_word_in = data_ff ^ {word_ff[30:0], gold_bit};
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (rsp_tready) begin
               rsp_valid_in = 1'b0;
               if (k_ff == 5'(WordCount - 1)) begin
                  state_in = S_IDLE;
               end else begin
                  k_in = k_ff + 1'b1;
                  state_in = S_RD;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cell_id_ff <= '0;
         cnt_ff <= '0;
         pos_ff <= '0;
         k_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cell_id_ff <= cell_id_in;
         cnt_ff <= cnt_in;
         pos_ff <= pos_in;
         k_ff <= k_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      p_ff <= p_in;
      pay_ff <= pay_in;
      crc_ff <= crc_in;
      ssb_ff <= ssb_in;
      word_ff <= word_in;
      data_ff <= data_in;
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = {3'b000, k_ff, rsp_word_ff};
   assign rsp_tlast = (k_ff == 5'(WordCount - 1));

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == 1'b0) ? {22'd0, cell_id_ff} : 32'd0;

endmodule
